// ===== sv/chs_pkg.sv =====
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants for the chained hash set.
// ----------------------------------------------------------------------------
package chs_pkg;

  // Bucket count register
  localparam int CFG_WIDTH = 5;
  localparam logic [CFG_WIDTH-1:0] CFG_RESET = 5'd10;

  // Default geometry
  localparam int DEF_MAX_BUCKETS = 16;
  localparam int DEF_WAYS        = 4;
  localparam int DEF_KEY_WIDTH   = 31;

  // Key bits consumed per cycle by the remainder unit
  localparam int DIGIT_BITS = 4;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_ERASE  = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

endpackage

// ===== sv/chained_hash_set.sv =====
// ----------------------------------------------------------------------------
// chained_hash_set
// Set of integer keys in a bucket RAM, hashed by key modulo bucket count.
// ----------------------------------------------------------------------------
//
//   channel  handshake                  payload
//   -------  -------------------------  --------------------------
//   input    in_valid / in_ready        command, key
//   output   out_valid / out_ready      was_present, status
//   config   cfg_write                  cfg_data (bucket count)
//
// A transaction runs through S_IDLE, S_DIV, S_READ and S_EVAL: the remainder
// unit retires four key bits a cycle in S_DIV, S_READ reads the bucket row and
// S_EVAL updates it and posts the result.
// After reset the bucket RAM is cleared one row a cycle with in_ready low. The
// output register lets the next transaction start while a result waits; a
// result that cannot be posted holds the update.
//
module chained_hash_set #(
  parameter int MAX_BUCKETS = chs_pkg::DEF_MAX_BUCKETS,
  parameter int WAYS        = chs_pkg::DEF_WAYS,
  parameter int KEY_WIDTH   = chs_pkg::DEF_KEY_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [chs_pkg::CFG_WIDTH-1:0]  cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     command,
  input  logic [KEY_WIDTH-1:0]           key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           was_present,
  output logic                           status
);

  localparam int CW      = chs_pkg::CFG_WIDTH;
  localparam int DIGIT   = chs_pkg::DIGIT_BITS;
  localparam int STEPS   = (KEY_WIDTH + DIGIT - 1) / DIGIT;
  localparam int KEY_PAD = STEPS * DIGIT;
  localparam int STEP_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int BW      = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int KEYS_W  = WAYS * KEY_WIDTH;
  localparam int ROW_W   = KEYS_W + WAYS;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_READ,
    S_EVAL
  } state_t;

  state_t                state;
  logic [CW-1:0]         bucket_count;
  logic [BW-1:0]         clr_addr;
  logic [1:0]            cmd;
  logic [KEY_WIDTH-1:0]  key_q;
  logic [KEY_PAD-1:0]    key_sh;
  logic [STEP_W-1:0]     step;
  logic [CW-1:0]         rem;
  logic [CW-1:0]         rem_next;
  logic [CW-1:0]         divisor;

  logic                  ram_we;
  logic [BW-1:0]         ram_waddr;
  logic [ROW_W-1:0]      ram_wdata;
  logic [ROW_W-1:0]      row;
  logic [ROW_W-1:0]      row_next;
  logic [BW-1:0]         bucket;

  logic                  found;
  logic                  have_free;
  logic [WW-1:0]         hit_way;
  logic [WW-1:0]         free_way;
  logic                  do_insert;
  logic                  do_erase;
  logic                  eval_fire;

  // Effective divisor: zero acts as one, large counts saturate
  always_comb begin
    if (bucket_count == '0) begin
      divisor = CW'(1);
    end else if (int'(bucket_count) > MAX_BUCKETS) begin
      divisor = CW'(MAX_BUCKETS);
    end else begin
      divisor = bucket_count;
    end
  end

  // Restoring remainder, DIGIT key bits per cycle, MSB first
  always_comb begin
    logic [CW:0] r_t;
    r_t      = '0;
    rem_next = rem;
    for (int i = 0; i < DIGIT; i++) begin
      r_t = {rem_next, key_sh[KEY_PAD-1-i]};
      if (r_t >= {1'b0, divisor}) begin
        r_t = r_t - {1'b0, divisor};
      end
      rem_next = r_t[CW-1:0];
    end
  end

  assign bucket = BW'(rem);

  // Bucket scan: first matching valid way, first free way
  always_comb begin
    found     = 1'b0;
    have_free = 1'b0;
    hit_way   = '0;
    free_way  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (row[KEYS_W + w]) begin
        if (!found && row[w*KEY_WIDTH +: KEY_WIDTH] == key_q) begin
          found   = 1'b1;
          hit_way = WW'(w);
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_way  = WW'(w);
      end
    end
  end

  assign eval_fire = (state == S_EVAL) && (!out_valid || out_ready);
  assign do_insert = (cmd == chs_pkg::CMD_INSERT) && !found && have_free;
  assign do_erase  = (cmd == chs_pkg::CMD_ERASE) && found;

  always_comb begin
    row_next = row;
    if (do_insert) begin
      row_next[32'(free_way)*KEY_WIDTH +: KEY_WIDTH] = key_q;
      row_next[KEYS_W + 32'(free_way)]               = 1'b1;
    end
    if (do_erase) begin
      row_next[KEYS_W + 32'(hit_way)] = 1'b0;
    end
  end

  // Clearing pass owns the write port until it ends; no forwarding needed
  // since the next read comes only after the S_IDLE and S_DIV states that follow any write-back.
  always_comb begin
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = eval_fire && (do_insert || do_erase);
      ram_waddr = bucket;
      ram_wdata = row_next;
    end
  end

  chs_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_BUCKETS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (state == S_READ),
    .rd_addr (bucket),
    .rd_data (row)
  );

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      bucket_count <= chs_pkg::CFG_RESET;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        bucket_count <= cfg_data;
      end
      if (eval_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + BW'(1);
          if (clr_addr == BW'(MAX_BUCKETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd    <= command;
            key_q  <= key;
            key_sh <= KEY_PAD'(key);
            rem    <= '0;
            step   <= STEP_W'(STEPS - 1);
            state  <= S_DIV;
          end
        end
        S_DIV: begin
          rem    <= rem_next;
          key_sh <= key_sh << DIGIT;
          step   <= step - STEP_W'(1);
          if (step == '0) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          // hold until the output register is free
          if (eval_fire) begin
            was_present <= found;
            status      <= (cmd == chs_pkg::CMD_INSERT) && !found && !have_free;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/chs_ram.sv =====
// ----------------------------------------------------------------------------
// chs_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module chs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                           wr_data,
  input  logic                                       rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                           rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
